// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the handle table allocator rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is high
`define HTA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define HTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/hta_pkg.sv -----
// types, constants and helper functions of the handle table allocator
// no dependencies
package hta_pkg;

  localparam int TABLE_SIZE = 1024;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int HIDX_W     = 16;
  localparam int DATA_W     = 32;
  localparam int TYPE_W     = 8;
  localparam int ROW_BITS   = 32;
  localparam int BIT_AW     = $clog2(ROW_BITS);
  localparam int ROWS       = (TABLE_SIZE + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [ROW_AW-1:0] LAST_ROW      = ROW_AW'(ROWS - 1);
  localparam logic [HIDX_W:0]   TABLE_SIZE_X  = (HIDX_W + 1)'(TABLE_SIZE);

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic              REG_LOOKUP_TYPE   = 1'b0;
  localparam logic [TYPE_W-1:0] LOOKUP_TYPE_RESET = 8'd1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [DATA_W-1:0] user_data;
    logic [TYPE_W-1:0] object_type;
    logic [HIDX_W-1:0] handle_index;
    logic [TYPE_W-1:0] handle_type;
  } request_t;

  typedef struct packed {
    logic              ok;
    logic [HIDX_W-1:0] out_index;
    logic [TYPE_W-1:0] out_type;
    logic [DATA_W-1:0] out_data;
  } result_t;

  typedef struct packed {
    logic                data_we;
    logic [IDX_W-1:0]    data_addr;
    logic [DATA_W-1:0]   data_wdata;
    logic                occ_re;
    logic [ROW_AW-1:0]   occ_raddr;
    logic                occ_we;
    logic [ROW_AW-1:0]   occ_waddr;
    logic [ROW_BITS-1:0] occ_wdata;
  } mem_req_t;

  typedef struct packed {
    logic              found;
    logic [BIT_AW-1:0] pos;
  } zero_hit_t;

  function automatic logic [ROW_AW-1:0] row_of(input logic [IDX_W-1:0] idx);
    return ROW_AW'(idx >> BIT_AW);
  endfunction

  function automatic logic [BIT_AW-1:0] bit_of(input logic [IDX_W-1:0] idx);
    return BIT_AW'(idx);
  endfunction

  function automatic logic [IDX_W-1:0] compose(input logic [ROW_AW-1:0] row,
                                               input logic [BIT_AW-1:0] pos);
    return (IDX_W'(row) << BIT_AW) | IDX_W'(pos);
  endfunction

  // bits of a row that lie past the end of the table count as used
  function automatic logic [ROW_BITS-1:0] pad_mask(input logic [ROW_AW-1:0] row);
    logic [ROW_BITS-1:0] m;
    m = '0;
    for (int b = 0; b < ROW_BITS; b++) begin
      m[b] = (int'(row) * ROW_BITS + b) >= TABLE_SIZE;
    end
    return m;
  endfunction

  function automatic zero_hit_t lowest_zero(input logic [ROW_BITS-1:0] w);
    zero_hit_t h;
    h = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (!w[b]) begin
        h.found = 1'b1;
        h.pos   = BIT_AW'(b);
      end
    end
    return h;
  endfunction

endpackage

// ----- rtl/core/hta_cfg.sv -----
// apb register block holding the accepted lookup type
// depends on hta_pkg
module hta_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [hta_pkg::TYPE_W-1:0] lookup_type
);
  import hta_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_LOOKUP_TYPE);

  always_ff @(posedge clk) begin
    if (rst) begin
      lookup_type <= LOOKUP_TYPE_RESET;
    end else if (wr_en) begin
      lookup_type <= pwdata[TYPE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LOOKUP_TYPE) ? {(32 - TYPE_W)'(0), lookup_type} : '0;

endmodule

// ----- rtl/core/hta_store.sv -----
// data word memory and occupancy bitmap memory with row valid bits
// depends on hta_pkg and assert_macros.svh
`include "assert_macros.svh"

module hta_store (
  input  logic                          clk,
  input  logic                          rst,
  input  hta_pkg::mem_req_t             mem,
  output logic [hta_pkg::DATA_W-1:0]    data_rdata,
  output logic [hta_pkg::ROW_BITS-1:0]  occ_rdata
);
  import hta_pkg::*;

  logic [DATA_W-1:0]   data_mem [TABLE_SIZE];
  logic [ROW_BITS-1:0] occ_mem [ROWS];
  logic [ROWS-1:0]     row_valid;
  logic [ROW_BITS-1:0] occ_raw;
  logic                valid_q;

  always_ff @(posedge clk) begin
    if (mem.data_we) begin
      data_mem[mem.data_addr] <= mem.data_wdata;
    end
    data_rdata <= data_mem[mem.data_addr];
  end

  always_ff @(posedge clk) begin
    if (mem.occ_we) begin
      occ_mem[mem.occ_waddr] <= mem.occ_wdata;
    end
    occ_raw <= occ_mem[mem.occ_raddr];
    valid_q <= row_valid[mem.occ_raddr];
  end

  // rows never written read as all free
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (mem.occ_we) begin
      row_valid[mem.occ_waddr] <= 1'b1;
    end
  end

  assign occ_rdata = valid_q ? occ_raw : '0;

  `HTA_ASSERT(a_occ_no_overlap, clk, rst,
    !(mem.occ_we && mem.occ_re && (mem.occ_waddr == mem.occ_raddr)),
    "occupancy row read and written in the same cycle")
  `HTA_ASSERT(a_row_valid_set, clk, rst,
    mem.occ_we |=> row_valid[$past(mem.occ_waddr)],
    "written occupancy row not marked valid")

endmodule

// ----- rtl/core/hta_ctrl.sv -----
// request sequencer: allocate, free, lookup and free-slot scan
// depends on hta_pkg and assert_macros.svh
`include "assert_macros.svh"

module hta_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  hta_pkg::request_t             request,
  output logic                          done,
  output hta_pkg::result_t              result,
  input  logic [hta_pkg::TYPE_W-1:0]    lookup_type,
  output hta_pkg::mem_req_t             mem,
  input  logic [hta_pkg::DATA_W-1:0]    data_rdata,
  input  logic [hta_pkg::ROW_BITS-1:0]  occ_rdata
);
  import hta_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ALLOC = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_FREE  = 3'd3;
  localparam logic [2:0] ST_LOOK  = 3'd4;

  logic [2:0]          state, state_next;
  request_t            cur, cur_next;
  logic [IDX_W-1:0]    lowest_free, lowest_free_next;
  logic                table_full, table_full_next;
  logic [ROW_AW-1:0]   scan_row, scan_row_next;
  logic                done_next;
  result_t             result_next;

  logic                in_range;
  logic [IDX_W-1:0]    cur_idx;
  logic [ROW_BITS-1:0] alloc_row, free_row, scan_word;
  zero_hit_t           alloc_hit, scan_hit;

  assign busy     = (state != ST_IDLE);
  assign in_range = {1'b0, request.handle_index} < TABLE_SIZE_X;
  assign cur_idx  = IDX_W'(cur.handle_index);

  assign alloc_row = occ_rdata |
    ((cur.user_data != '0) ? (ROW_BITS'(1) << bit_of(lowest_free)) : '0);
  assign alloc_hit = lowest_zero(alloc_row | pad_mask(row_of(lowest_free)));
  assign scan_word = occ_rdata | pad_mask(scan_row);
  assign scan_hit  = lowest_zero(scan_word);
  assign free_row  = occ_rdata & ~(ROW_BITS'(1) << bit_of(cur_idx));

  always_comb begin
    state_next       = state;
    cur_next         = cur;
    lowest_free_next = lowest_free;
    table_full_next  = table_full;
    scan_row_next    = scan_row;
    done_next        = 1'b0;
    result_next      = result;
    mem              = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          cur_next    = request;
          result_next = '0;
          mem.data_addr = IDX_W'(request.handle_index);
          case (request.cmd)
            CMD_ALLOC: begin
              if (!table_full) begin
                mem.data_we    = 1'b1;
                mem.data_addr  = lowest_free;
                mem.data_wdata = request.user_data;
                mem.occ_re     = 1'b1;
                mem.occ_raddr  = row_of(lowest_free);
                state_next     = ST_ALLOC;
              end else begin
                done_next = 1'b1;
              end
            end
            CMD_FREE: begin
              if (in_range) begin
                mem.occ_re    = 1'b1;
                mem.occ_raddr = row_of(IDX_W'(request.handle_index));
                state_next    = ST_FREE;
              end else begin
                result_next.ok = 1'b1;
                done_next      = 1'b1;
              end
            end
            CMD_LOOKUP: begin
              if (in_range && (request.handle_type == lookup_type)) begin
                mem.occ_re    = 1'b1;
                mem.occ_raddr = row_of(IDX_W'(request.handle_index));
                state_next    = ST_LOOK;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_ALLOC: begin
        result_next.ok        = 1'b1;
        result_next.out_index = HIDX_W'(lowest_free);
        result_next.out_type  = cur.object_type;
        mem.occ_we    = 1'b1;
        mem.occ_waddr = row_of(lowest_free);
        mem.occ_wdata = alloc_row;
        if (alloc_hit.found) begin
          lowest_free_next = compose(row_of(lowest_free), alloc_hit.pos);
          done_next        = 1'b1;
          state_next       = ST_IDLE;
        end else if (row_of(lowest_free) == LAST_ROW) begin
          table_full_next = 1'b1;
          done_next       = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          scan_row_next = row_of(lowest_free) + ROW_AW'(1);
          mem.occ_re    = 1'b1;
          mem.occ_raddr = row_of(lowest_free) + ROW_AW'(1);
          state_next    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (scan_hit.found) begin
          lowest_free_next = compose(scan_row, scan_hit.pos);
          done_next        = 1'b1;
          state_next       = ST_IDLE;
        end else if (scan_row == LAST_ROW) begin
          table_full_next = 1'b1;
          done_next       = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          scan_row_next = scan_row + ROW_AW'(1);
          mem.occ_re    = 1'b1;
          mem.occ_raddr = scan_row + ROW_AW'(1);
        end
      end

      ST_FREE: begin
        mem.occ_we    = 1'b1;
        mem.occ_waddr = row_of(cur_idx);
        mem.occ_wdata = free_row;
        if (table_full || (cur_idx < lowest_free)) begin
          lowest_free_next = cur_idx;
        end
        table_full_next = 1'b0;
        result_next.ok  = 1'b1;
        done_next       = 1'b1;
        state_next      = ST_IDLE;
      end

      ST_LOOK: begin
        result_next.ok       = 1'b1;
        result_next.out_data = occ_rdata[bit_of(cur_idx)] ? data_rdata : '0;
        done_next            = 1'b1;
        state_next           = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      lowest_free <= '0;
      table_full  <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      lowest_free <= lowest_free_next;
      table_full  <= table_full_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    scan_row <= scan_row_next;
    result   <= result_next;
  end

  `HTA_ASSERT(a_done_in_idle, clk, rst,
    done |-> (state == ST_IDLE),
    "result strobe while a request is still in progress")
  `HTA_ASSERT(a_scan_not_full, clk, rst,
    (state == ST_SCAN) |-> !table_full,
    "free-slot scan running with the table marked full")
  `HTA_ASSERT(a_free_clears_full, clk, rst,
    (state == ST_FREE) |=> (!table_full && done),
    "in-range free did not clear the full flag")

endmodule

// ----- rtl/core/handle_table_allocator_core.sv -----
// top level of the handle table allocator
// depends on hta_pkg, hta_cfg, hta_store and hta_ctrl
//
// A request is taken when start is high and busy is low; its result appears on result
// for exactly one cycle with done high and cannot be held off by the receiver. A free
// or lookup of a valid handle reads the occupancy bitmap and data memories at the
// accepting edge; the FREE or LOOK state then updates and registers result and done.
// Rejected requests show done on the cycle after acceptance. An allocate reads the
// bitmap row of the lowest free index, then the search for the next free slot reads one
// 32-entry bitmap row per cycle from the occupancy memory until it finds one or reaches
// the last row of the 1024-entry table. A new request can be taken in the same cycle
// that done is shown. Occupancy rows carry reset-cleared valid bits, so the block is
// ready directly after reset with no clearing pass. lookup_type sits at address 0 of
// the apb port.
module handle_table_allocator_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  hta_pkg::request_t   request,
  output logic                done,
  output hta_pkg::result_t    result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import hta_pkg::*;

  logic [TYPE_W-1:0]   lookup_type;
  mem_req_t            mem;
  logic [DATA_W-1:0]   data_rdata;
  logic [ROW_BITS-1:0] occ_rdata;

  hta_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .lookup_type (lookup_type)
  );

  hta_store u_store (
    .clk        (clk),
    .rst        (rst),
    .mem        (mem),
    .data_rdata (data_rdata),
    .occ_rdata  (occ_rdata)
  );

  hta_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .lookup_type (lookup_type),
    .mem         (mem),
    .data_rdata  (data_rdata),
    .occ_rdata   (occ_rdata)
  );

endmodule

// ----- bench/handle_table_checker.sv -----
// request/result checker for the handle table allocator core
// keeps its own table, free index and lookup type; depends on hta_pkg
`timescale 1ns / 1ps

module handle_table_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  hta_pkg::request_t request,
  input  logic              done,
  input  hta_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                pending,
  output int                errors
);
  import hta_pkg::*;

  localparam logic [2:0] LOOKUP_TYPE_ADDR = 3'(REG_LOOKUP_TYPE) << 2;

  logic [DATA_W-1:0] slot_word [TABLE_SIZE];
  int                first_free;
  logic              all_taken;
  logic [TYPE_W-1:0] accepted_type;
  result_t           expected_results [$];

  function automatic result_t predict_result(request_t r);
    result_t res;
    res = '0;
    case (r.cmd)
      CMD_ALLOC: begin
        if (!all_taken) begin
          res.ok        = 1'b1;
          res.out_index = HIDX_W'(first_free);
          res.out_type  = r.object_type;
          slot_word[first_free] = r.user_data;
          all_taken = 1'b1;
          for (int i = 0; i < TABLE_SIZE; i++) begin
            if (all_taken && slot_word[i] == '0) begin
              first_free = i;
              all_taken  = 1'b0;
            end
          end
        end
      end
      CMD_FREE: begin
        res.ok = 1'b1;
        if (r.handle_index < TABLE_SIZE) begin
          slot_word[r.handle_index] = '0;
          if (all_taken || r.handle_index < first_free) first_free = r.handle_index;
          all_taken = 1'b0;
        end
      end
      CMD_LOOKUP: begin
        if (r.handle_type == accepted_type && r.handle_index < TABLE_SIZE) begin
          res.ok       = 1'b1;
          res.out_data = slot_word[r.handle_index];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) slot_word[i] = '0;
      first_free    = 0;
      all_taken     = 1'b0;
      accepted_type = LOOKUP_TYPE_RESET;
      errors        = 0;
      expected_results.delete();
    end else begin
      if (done === 1'b1) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request outstanding: ok=%0b index=%0h type=%0h data=%0h",
                   $time, result.ok, result.out_index, result.out_type, result.out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result.ok !== want.ok || result.out_index !== want.out_index ||
              result.out_type !== want.out_type || result.out_data !== want.out_data) begin
            $display("%0t: expected ok=%0b index=%0h type=%0h data=%0h,",
                     $time, want.ok, want.out_index, want.out_type, want.out_data);
            $display("%0t: got ok=%0b index=%0h type=%0h data=%0h",
                     $time, result.ok, result.out_index, result.out_type, result.out_data);
            errors++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(predict_result(request));
      if (psel && penable && pready && paddr == LOOKUP_TYPE_ADDR) begin
        if (pwrite) begin
          accepted_type = pwdata[TYPE_W-1:0];
        end else if (prdata[TYPE_W-1:0] !== accepted_type) begin
          $display("%0t: lookup_type read expected %0h, got %0h",
                   $time, accepted_type, prdata[TYPE_W-1:0]);
          errors++;
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ----- bench/handle_table_allocator_core_test.sv -----
// top of the handle table allocator core testbench: clock, reset, requests, apb traffic
// depends on hta_pkg, handle_table_allocator_core and handle_table_checker
`timescale 1ns / 1ps

module handle_table_allocator_core_test;
  import hta_pkg::*;

  localparam logic [1:0] CMD_UNUSED       = 2'd3;
  localparam logic [2:0] LOOKUP_TYPE_ADDR = 3'(REG_LOOKUP_TYPE) << 2;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  request_t    request;
  logic        done;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          pending;
  int          errors;

  logic [TYPE_W-1:0] cur_lookup;
  logic              steady;

  handle_table_allocator_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  handle_table_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pending (pending),
    .errors  (errors)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic request_t make_request(logic [1:0] cmd, logic [DATA_W-1:0] data,
                                            logic [TYPE_W-1:0] otype,
                                            logic [HIDX_W-1:0] idx,
                                            logic [TYPE_W-1:0] htype);
    request_t r;
    r.cmd          = cmd;
    r.user_data    = data;
    r.object_type  = otype;
    r.handle_index = idx;
    r.handle_type  = htype;
    return r;
  endfunction

  function automatic request_t random_request(int alloc_pct);
    request_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) r.cmd = CMD_ALLOC;
    else if (pick < alloc_pct + (97 - alloc_pct) / 2) r.cmd = CMD_FREE;
    else if (pick < 97) r.cmd = CMD_LOOKUP;
    else r.cmd = CMD_UNUSED;
    case ($urandom_range(0, 9))
      0: r.user_data = '0;
      1: r.user_data = '1;
      default: r.user_data = $urandom;
    endcase
    r.object_type = TYPE_W'($urandom);
    case ($urandom_range(0, 9))
      0: r.handle_index = HIDX_W'($urandom_range(TABLE_SIZE, 65535));
      1, 2: r.handle_index = HIDX_W'($urandom_range(0, TABLE_SIZE - 1));
      3: r.handle_index = $urandom_range(0, 1) ? HIDX_W'(TABLE_SIZE - 1) : '1;
      default: r.handle_index = HIDX_W'($urandom_range(0, 63));
    endcase
    r.handle_type = ($urandom_range(0, 9) < 8) ? cur_lookup : TYPE_W'($urandom);
    return r;
  endfunction

  task automatic send(request_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LOOKUP_TYPE_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_lookup_type(logic [TYPE_W-1:0] value);
    settle();
    apb_access(1'b1, {24'($urandom), value});
    apb_access(1'b0, '0);
    cur_lookup = value;
  endtask

  task automatic random_phase(int count, int alloc_pct);
    repeat (count) send(random_request(alloc_pct));
  endtask

  task automatic alloc_run(int count);
    repeat (count) send(make_request(CMD_ALLOC, $urandom | 32'd1, TYPE_W'($urandom),
                                     HIDX_W'($urandom), TYPE_W'($urandom)));
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    cur_lookup = LOOKUP_TYPE_RESET;
    steady     = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset value of lookup_type, then edge cases of the table
    apb_access(1'b0, '0);
    send(make_request(CMD_LOOKUP, '0, '0, '0, cur_lookup));
    send(make_request(CMD_ALLOC, '0, '0, '1, '0));
    send(make_request(CMD_ALLOC, '0, 8'h5a, '0, '0));
    send(make_request(CMD_ALLOC, '1, '1, '0, '0));
    send(make_request(CMD_ALLOC, 32'd1, 8'd1, '0, '0));
    send(make_request(CMD_LOOKUP, '0, '0, '0, cur_lookup));
    send(make_request(CMD_LOOKUP, '0, '0, '0, '0));
    send(make_request(CMD_LOOKUP, '0, '0, HIDX_W'(TABLE_SIZE - 1), cur_lookup));
    send(make_request(CMD_LOOKUP, '0, '0, HIDX_W'(TABLE_SIZE), cur_lookup));
    send(make_request(CMD_LOOKUP, '1, '1, '1, cur_lookup));
    send(make_request(CMD_FREE, '0, '0, '1, '0));
    send(make_request(CMD_FREE, '0, '0, HIDX_W'(TABLE_SIZE), '0));
    send(make_request(CMD_FREE, '0, '0, '0, '0));
    send(make_request(CMD_ALLOC, 32'h8000_0000, 8'h80, '0, '0));
    send(make_request(CMD_FREE, '1, '1, HIDX_W'(TABLE_SIZE - 1), '1));
    send(make_request(CMD_UNUSED, '1, '1, '1, '1));
    send(make_request(CMD_UNUSED, '0, '0, '0, '0));
    send(make_request(CMD_ALLOC, 32'h5a5a_a5a5, 8'h7f, '0, '0));
    send(make_request(CMD_LOOKUP, '0, '0, 16'd1, cur_lookup));

    set_lookup_type('1);
    send(make_request(CMD_LOOKUP, '0, '0, '0, '1));
    send(make_request(CMD_LOOKUP, '0, '0, '0, 8'd1));
    set_lookup_type('0);
    send(make_request(CMD_LOOKUP, '0, '0, '0, '0));
    send(make_request(CMD_LOOKUP, '0, '0, 16'd2, '0));

    set_lookup_type(TYPE_W'($urandom));
    random_phase(150, 45);
    steady = 1'b1;
    random_phase(50, 40);

    // long allocate runs so the free-slot search crosses bitmap rows
    set_lookup_type(8'd1);
    steady = 1'b0;
    alloc_run(150);
    steady = 1'b1;
    alloc_run(150);
    steady = 1'b0;
    random_phase(100, 35);

    set_lookup_type('1);
    random_phase(40, 50);
    set_lookup_type(TYPE_W'($urandom));
    steady = 1'b1;
    random_phase(30, 30);
    steady = 1'b0;
    random_phase(30, 30);

    settle();
    if (errors == 0) begin
      $display("** handle_table_allocator_core: PASSED **");
    end else begin
      $display("** handle_table_allocator_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("** handle_table_allocator_core: FAILED **");
    $finish;
  end

endmodule
